// File: rtl/hrs_pkg.sv
// ----------------------------------------------------------------------------
// hrs_pkg
// shared types and constants of the homography reprojection scorer
// ----------------------------------------------------------------------------
package hrs_pkg;

   typedef enum logic [2:0] {
      REG_H00_H01 = 3'd0,
      REG_H02_H10 = 3'd1,
      REG_H11_H12 = 3'd2,
      REG_H20_H21 = 3'd3,
      REG_H22     = 3'd4,
      REG_MODE    = 3'd5
   } reg_idx_type;

   localparam logic [63:0] RST_H00_H01 = 64'h0100_0000_0000_0000;
   localparam logic [63:0] RST_H02_H10 = 64'h0;
   localparam logic [63:0] RST_H11_H12 = 64'h0100_0000_0000_0000;
   localparam logic [63:0] RST_H20_H21 = 64'h0;
   localparam logic [31:0] RST_H22     = 32'h0100_0000;

   localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

   // iteration counts of the shared units
   localparam int MUL_STEPS  = 9;
   localparam int SQ_STEPS   = 3;
   localparam int DIV_STEPS  = 33;
   localparam int ROOT_STEPS = 32;

   typedef struct packed {
      logic       ready;
      logic       mul_go;
      logic       sq_go;
      logic [3:0] idx;
      logic       div_init;
      logic       div_step;
      logic       fix;
      logic       root_init;
      logic       root_step;
      logic       update;
   } cmd_type;

   typedef struct packed {
      logic in_valid;
      logic zden;
      logic out_free;
   } status_type;

endpackage

// File: rtl/hrs_if.sv
// ----------------------------------------------------------------------------
// hrs_if
// channel interfaces of the homography reprojection scorer
// ----------------------------------------------------------------------------
interface hrs_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] src_x;
   logic signed [31:0] src_y;
   logic signed [31:0] src_w;
   logic signed [31:0] dst_x;
   logic signed [31:0] dst_y;
   logic signed [31:0] dst_w;
   logic               last_point;

   modport source (output valid, src_x, src_y, src_w, dst_x, dst_y, dst_w, last_point,
                   input ready);
   modport sink   (input valid, src_x, src_y, src_w, dst_x, dst_y, dst_w, last_point,
                   output ready);
endinterface

interface hrs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic [31:0]        distance;
   logic               zero_denominator;
   logic               set_done;
   logic [47:0]        error_sum;
   logic [31:0]        max_error;
   logic [9:0]         max_index;
   logic               set_error;

   modport source (output valid, out_x, out_y, distance, zero_denominator, set_done,
                   error_sum, max_error, max_index, set_error, input ready);
   modport sink   (input valid, out_x, out_y, distance, zero_denominator, set_done,
                   error_sum, max_error, max_index, set_error, output ready);
endinterface

interface hrs_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/hrs_ctrl.sv
// ----------------------------------------------------------------------------
// hrs_ctrl
// sequencer: steps the datapath through products, divides, squares and root
// ----------------------------------------------------------------------------
module hrs_ctrl
   import hrs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  status_type sts,
   output cmd_type    cmd
);

   typedef enum logic [10:0] {
      S_IDLE    = 11'b000_0000_0001,
      S_MUL     = 11'b000_0000_0010,
      S_MDRAIN  = 11'b000_0000_0100,
      S_CHK     = 11'b000_0000_1000,
      S_DIV     = 11'b000_0001_0000,
      S_FIX     = 11'b000_0010_0000,
      S_SQ      = 11'b000_0100_0000,
      S_SQDRAIN = 11'b000_1000_0000,
      S_RINIT   = 11'b001_0000_0000,
      S_ROOT    = 11'b010_0000_0000,
      S_UPD     = 11'b100_0000_0000
   } state_type;

   state_type  state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.ready = 1'b1;
            if (sts.in_valid) begin
               state_in = S_MUL;
               cnt_in   = '0;
            end
         end
         S_MUL: begin
            cmd.mul_go = 1'b1;
            cmd.idx    = cnt_ff[3:0];
            if (cnt_ff == 6'(MUL_STEPS - 1)) state_in = S_MDRAIN;
            else cnt_in = cnt_ff + 6'd1;
         end
         S_MDRAIN: state_in = S_CHK;
         S_CHK: begin
            if (sts.zden) begin
               state_in = S_UPD;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = S_DIV;
               cnt_in       = '0;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == 6'(DIV_STEPS - 1)) state_in = S_FIX;
            else cnt_in = cnt_ff + 6'd1;
         end
         S_FIX: begin
            cmd.fix  = 1'b1;
            state_in = S_SQ;
            cnt_in   = '0;
         end
         S_SQ: begin
            cmd.sq_go = 1'b1;
            cmd.idx   = cnt_ff[3:0];
            if (cnt_ff == 6'(SQ_STEPS - 1)) state_in = S_SQDRAIN;
            else cnt_in = cnt_ff + 6'd1;
         end
         S_SQDRAIN: state_in = S_RINIT;
         S_RINIT: begin
            cmd.root_init = 1'b1;
            state_in      = S_ROOT;
            cnt_in        = '0;
         end
         S_ROOT: begin
            cmd.root_step = 1'b1;
            if (cnt_ff == 6'(ROOT_STEPS - 1)) state_in = S_UPD;
            else cnt_in = cnt_ff + 6'd1;
         end
         S_UPD: begin
            if (sts.out_free) begin
               cmd.update = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// File: rtl/hrs_dp.sv
// ----------------------------------------------------------------------------
// hrs_dp
// datapath: coefficient registers, shared multiplier, divider lanes, root, stats
// ----------------------------------------------------------------------------
module hrs_dp
   import hrs_pkg::*;
#(
   parameter int MAX_POINTS = 1024
) (
   input  logic       clock,
   input  logic       reset,
   hrs_req_if.sink    req,
   hrs_rsp_if.source  rsp,
   hrs_csr_if.sink    csr,
   input  cmd_type    cmd,
   output status_type sts
);

   localparam int CW = $clog2(MAX_POINTS);
   localparam int PW = (CW > 10) ? CW : 10;

   function automatic logic [63:0] mag66(input logic signed [65:0] v);
      logic [65:0] t;
      t = v[65] ? 66'(-v) : 66'(v);
      return t[63:0];
   endfunction

   function automatic logic signed [31:0] sat_q(input logic [32:0] q, input logic ovf,
                                               input logic neg);
      logic signed [31:0] r;
      if (neg) begin
         if (ovf || q >= 33'h0_8000_0000) r = 32'sh8000_0000;
         else r = -$signed(q[31:0]);
      end else begin
         if (ovf || q > 33'h0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
         else r = $signed(q[31:0]);
      end
      return r;
   endfunction

   // configuration
   logic [63:0] c0_ff, c1_ff, c2_ff, c3_ff;
   logic [31:0] c4_ff;
   logic        mode_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         c0_ff   <= RST_H00_H01;
         c1_ff   <= RST_H02_H10;
         c2_ff   <= RST_H11_H12;
         c3_ff   <= RST_H20_H21;
         c4_ff   <= RST_H22;
         mode_ff <= 1'b0;
      end else if (csr.valid) begin
         case (reg_idx_type'(csr.index))
            REG_H00_H01: c0_ff   <= csr.data;
            REG_H02_H10: c1_ff   <= csr.data;
            REG_H11_H12: c2_ff   <= csr.data;
            REG_H20_H21: c3_ff   <= csr.data;
            REG_H22:     c4_ff   <= csr.data[31:0];
            REG_MODE:    mode_ff <= csr.data[0];
            default: ;
         endcase
      end
   end

   // input word capture
   logic               load;
   logic signed [31:0] sx_ff, sy_ff, sw_ff, dx_ff, dy_ff, dw_ff;
   logic               last_ff;

   assign req.ready    = cmd.ready;
   assign load         = cmd.ready && req.valid;
   assign sts.in_valid = req.valid;

   always_ff @(posedge clock) begin
      if (load) begin
         sx_ff   <= req.src_x;
         sy_ff   <= req.src_y;
         sw_ff   <= mode_ff ? req.src_w : $signed(ONE_Q16);
         dx_ff   <= req.dst_x;
         dy_ff   <= req.dst_y;
         dw_ff   <= req.dst_w;
         last_ff <= req.last_point;
      end
   end

   // shared multiplier
   logic signed [32:0] op_a, op_b;
   logic signed [65:0] prod_ff;
   logic [1:0]         tgt_ff, tgt;
   logic               prod_vld_ff;
   logic signed [31:0] px_ff, py_ff;
   logic [32:0]        ex, ey, ew;
   logic [31:0]        mx, my, mw;

   assign ex = 33'({px_ff[31], px_ff} - {dx_ff[31], dx_ff});
   assign ey = 33'({py_ff[31], py_ff} - {dy_ff[31], dy_ff});
   assign ew = 33'({1'b0, ONE_Q16} - {dw_ff[31], dw_ff});
   assign mx = ex[32] ? 32'(-ex) : ex[31:0];
   assign my = ey[32] ? 32'(-ey) : ey[31:0];
   assign mw = mode_ff ? (ew[32] ? 32'(-ew) : ew[31:0]) : 32'd0;

   always_comb begin
      op_a = '0;
      op_b = '0;
      tgt  = 2'd3;
      if (cmd.sq_go) begin
         case (cmd.idx)
            4'd0:    begin op_a = {1'b0, mx}; op_b = {1'b0, mx}; end
            4'd1:    begin op_a = {1'b0, my}; op_b = {1'b0, my}; end
            4'd2:    begin op_a = {1'b0, mw}; op_b = {1'b0, mw}; end
            default: ;
         endcase
      end else begin
         case (cmd.idx)
            4'd0: begin op_a = 33'($signed(c0_ff[63:32])); op_b = 33'(sx_ff); tgt = 2'd0; end
            4'd1: begin op_a = 33'($signed(c0_ff[31:0]));  op_b = 33'(sy_ff); tgt = 2'd0; end
            4'd2: begin op_a = 33'($signed(c1_ff[63:32])); op_b = 33'(sw_ff); tgt = 2'd0; end
            4'd3: begin op_a = 33'($signed(c1_ff[31:0]));  op_b = 33'(sx_ff); tgt = 2'd1; end
            4'd4: begin op_a = 33'($signed(c2_ff[63:32])); op_b = 33'(sy_ff); tgt = 2'd1; end
            4'd5: begin op_a = 33'($signed(c2_ff[31:0]));  op_b = 33'(sw_ff); tgt = 2'd1; end
            4'd6: begin op_a = 33'($signed(c3_ff[63:32])); op_b = 33'(sx_ff); tgt = 2'd2; end
            4'd7: begin op_a = 33'($signed(c3_ff[31:0]));  op_b = 33'(sy_ff); tgt = 2'd2; end
            4'd8: begin op_a = 33'($signed(c4_ff));        op_b = 33'(sw_ff); tgt = 2'd2; end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
      tgt_ff  <= tgt;
      if (reset) prod_vld_ff <= 1'b0;
      else prod_vld_ff <= cmd.mul_go || cmd.sq_go;
   end

   // row sums and sum of squares
   logic signed [65:0] acc0_ff, acc1_ff, acc2_ff;
   logic [65:0]        sq_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         acc0_ff <= '0;
         acc1_ff <= '0;
         acc2_ff <= '0;
      end else if (prod_vld_ff) begin
         case (tgt_ff)
            2'd0:    acc0_ff <= acc0_ff + prod_ff;
            2'd1:    acc1_ff <= acc1_ff + prod_ff;
            2'd2:    acc2_ff <= acc2_ff + prod_ff;
            default: ;
         endcase
      end
      if (cmd.fix) sq_ff <= '0;
      else if (prod_vld_ff && tgt_ff == 2'd3) sq_ff <= sq_ff + $unsigned(prod_ff);
   end

   logic zden;
   assign zden     = (acc2_ff == '0);
   assign sts.zden = zden;

   // two restoring divider lanes, x and y, one quotient bit a cycle
   logic [63:0] den_ff;
   logic [63:0] rem_ff [2];
   logic [32:0] nb_ff  [2];
   logic [32:0] q_ff   [2];
   logic        ovf_ff [2];
   logic        neg_ff [2];

   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [63:0] num;
      logic [64:0] t;
      logic        ge;

      assign num = mag66(l == 0 ? acc0_ff : acc1_ff);
      assign t   = {rem_ff[l], nb_ff[l][32]};
      assign ge  = (t >= {1'b0, den_ff});

      always_ff @(posedge clock) begin
         if (cmd.div_init) begin
            ovf_ff[l] <= ({17'd0, num[63:17]} >= mag66(acc2_ff));
            rem_ff[l] <= ({17'd0, num[63:17]} >= mag66(acc2_ff)) ? 64'd0
                                                                 : {17'd0, num[63:17]};
            nb_ff[l]  <= {num[16:0], 16'd0};
            q_ff[l]   <= '0;
            neg_ff[l] <= (l == 0 ? acc0_ff[65] : acc1_ff[65]) ^ acc2_ff[65];
         end else if (cmd.div_step) begin
            rem_ff[l] <= ge ? 64'(t - {1'b0, den_ff}) : t[63:0];
            q_ff[l]   <= {q_ff[l][31:0], ge};
            nb_ff[l]  <= {nb_ff[l][31:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_init) den_ff <= mag66(acc2_ff);
      if (cmd.fix) begin
         px_ff <= sat_q(q_ff[0], ovf_ff[0], neg_ff[0]);
         py_ff <= sat_q(q_ff[1], ovf_ff[1], neg_ff[1]);
      end
   end

   // integer square root, one result bit a cycle
   logic [63:0] rn_ff, res_ff, bit_ff, trial;
   logic        rsat_ff;

   assign trial = res_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (cmd.root_init) begin
         rn_ff   <= sq_ff[63:0];
         res_ff  <= '0;
         bit_ff  <= 64'h4000_0000_0000_0000;
         rsat_ff <= |sq_ff[65:64];
      end else if (cmd.root_step) begin
         if (rn_ff >= trial) begin
            rn_ff  <= rn_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   // set statistics
   logic [47:0]   sum_ff, sum_in;
   logic [31:0]   max_ff, max_in, dist_val;
   logic [CW-1:0] pos_ff, pos_in, cnt_ff, cnt_in;
   logic          err_ff, err_in;
   logic [48:0]   sum_wide;
   logic [PW-1:0] pos_ext;

   assign dist_val = zden ? 32'd0 : (rsat_ff ? 32'hFFFF_FFFF : res_ff[31:0]);
   assign sum_wide = {1'b0, sum_ff} + {17'd0, dist_val};
   assign pos_ext  = PW'(pos_in);

   always_comb begin
      sum_in = sum_ff;
      max_in = max_ff;
      pos_in = pos_ff;
      err_in = err_ff | zden;
      cnt_in = (cnt_ff == CW'(MAX_POINTS - 1)) ? '0 : cnt_ff + 1'b1;
      if (!zden) begin
         sum_in = sum_wide[48] ? 48'hFFFF_FFFF_FFFF : sum_wide[47:0];
         if (dist_val > max_ff) begin
            max_in = dist_val;
            pos_in = cnt_ff;
         end
      end
   end

   logic rsp_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff     <= '0;
         max_ff     <= '0;
         pos_ff     <= '0;
         cnt_ff     <= '0;
         err_ff     <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (cmd.update) begin
            rsp_vld_ff <= 1'b1;
            if (last_ff) begin
               sum_ff <= '0;
               max_ff <= '0;
               pos_ff <= '0;
               cnt_ff <= '0;
               err_ff <= 1'b0;
            end else begin
               sum_ff <= sum_in;
               max_ff <= max_in;
               pos_ff <= pos_in;
               cnt_ff <= cnt_in;
               err_ff <= err_in;
            end
         end else if (rsp.ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp.out_x            <= zden ? 32'sd0 : px_ff;
         rsp.out_y            <= zden ? 32'sd0 : py_ff;
         rsp.distance         <= dist_val;
         rsp.zero_denominator <= zden;
         rsp.set_done         <= last_ff;
         rsp.error_sum        <= sum_in;
         rsp.max_error        <= max_in;
         rsp.max_index        <= pos_ext[9:0];
         rsp.set_error        <= err_in;
      end
   end

   assign rsp.valid    = rsp_vld_ff;
   assign sts.out_free = !rsp_vld_ff || rsp.ready;

   // checks
   a_upd_free: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> (!rsp_vld_ff || rsp.ready))
      else $error("result loaded over a word not yet taken");

   a_upd_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> rsp_vld_ff)
      else $error("loaded result not offered");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.div_step) && !$past(cmd.div_init) |-> rem_ff[0] < den_ff)
      else $error("divider remainder not below divisor");

   a_max_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && !rsp.zero_denominator |-> rsp.max_error >= rsp.distance)
      else $error("maximum below current distance");

endmodule

// File: rtl/homography_reprojection_scorer.sv
// ----------------------------------------------------------------------------
// homography_reprojection_scorer
// maps point correspondences through a 3x3 homography and scores the error
// ----------------------------------------------------------------------------
// req_ch carries one correspondence per word (source x,y,w, target x,y,w and
// last_point); rsp_ch returns one result word per request: projected point,
// distance, zero denominator flag and the running set statistics.
// csr_ch writes the coefficient and mode registers, always ready, one per cycle.
// an item passes from accept to result through nine products on the shared 33x33
// multiplier, the 33-step divider pair, three squares and the 32-step square
// root, divider and root both one bit a cycle; a zero denominator skips all but the products.
// a new request is taken in the cycle after the previous result is loaded, so
// the block does not take a new item before it is through with the last one.
// the result sits in an output register: a stalled receiver does not block
// the next request; the sequencer only waits at the final load if that
// register still holds an untaken word.
// reset restores the identity homography, cartesian mode and clears the set
// statistics and any pending result.
// ----------------------------------------------------------------------------
module homography_reprojection_scorer
   import hrs_pkg::*;
#(
   parameter int MAX_POINTS = 1024
) (
   input logic       clock,
   input logic       reset,
   hrs_req_if.sink   req_ch,
   hrs_rsp_if.source rsp_ch,
   hrs_csr_if.sink   csr_ch
);

   // command and status between sequencer and datapath
   cmd_type    cmd;
   status_type sts;

   hrs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   // datapath holds registers, arithmetic units and the output word
   hrs_dp #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch),
      .cmd   (cmd),
      .sts   (sts)
   );

endmodule

// File: tb/sv/homography_reprojection_scorer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// homography_reprojection_scorer_checker
// watches the three channels, predicts every result word and compares it
// ----------------------------------------------------------------------------
module homography_reprojection_scorer_checker
   import hrs_pkg::*;
#(
   parameter int MAX_POINTS = 1024
) (
   input  logic clock,
   input  logic reset,
   hrs_req_if   req_ch,
   hrs_rsp_if   rsp_ch,
   hrs_csr_if   csr_ch,
   output int   fail_count,
   output int   pending,
   output int   results_seen,
   output int   zden_seen
);

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic [31:0]        distance;
      logic               zero_denominator;
      logic               set_done;
      logic [47:0]        error_sum;
      logic [31:0]        max_error;
      logic [9:0]         max_index;
      logic               set_error;
   } score_type;

   score_type   score_q[$];
   logic [63:0] coef_reg [0:4];
   logic        homog;
   logic [47:0] sum_acc;
   logic [31:0] max_dist;
   logic [9:0]  max_pos;
   logic [9:0]  pos_count;
   logic        err_seen;

   function automatic logic signed [127:0] row_dot(input logic signed [31:0] a, b, c,
                                                 input logic signed [31:0] x, y, w);
      longint pa, pb, pc;
      logic signed [127:0] s;
      pa = longint'(a) * longint'(x);
      pb = longint'(b) * longint'(y);
      pc = longint'(c) * longint'(w);
      s = pa;
      s = s + pb;
      s = s + pc;
      return s;
   endfunction

   // (num * 2^16) / den, truncated toward zero, clamped to 32 bits signed
   function automatic logic signed [31:0] fix_div(input logic signed [127:0] num, den);
      logic [127:0] nm, dm, q;
      logic         neg;
      nm  = num[127] ? -num : num;
      dm  = den[127] ? -den : den;
      neg = num[127] ^ den[127];
      q   = (nm << 16) / dm;
      if (neg)
         return (q >= 128'h8000_0000) ? 32'sh8000_0000 : 32'(-q);
      return (q > 128'h7fff_ffff) ? 32'sh7fff_ffff : 32'(q);
   endfunction

   function automatic logic [31:0] int_sqrt(input logic [63:0] n);
      logic [63:0] res, b;
      res = 0;
      b   = 64'h4000_0000_0000_0000;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n   = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res[31:0];
   endfunction

   function automatic logic [127:0] square_of(input longint d);
      logic [63:0] m;
      m = (d < 0) ? -d : d;
      return 128'(m) * 128'(m);
   endfunction

   // one correspondence through the homography, updating the set statistics
   function automatic score_type score_point(input logic signed [31:0] sx, sy, sw_in,
                                             input logic signed [31:0] tx, ty, tw,
                                             input logic last);
      score_type r;
      logic signed [31:0] sw;
      logic signed [127:0] u, v, w;
      logic [127:0] acc;
      r  = '0;
      sw = homog ? sw_in : ONE_Q16;
      u = row_dot(coef_reg[0][63:32], coef_reg[0][31:0], coef_reg[1][63:32], sx, sy, sw);
      v = row_dot(coef_reg[1][31:0], coef_reg[2][63:32], coef_reg[2][31:0], sx, sy, sw);
      w = row_dot(coef_reg[3][63:32], coef_reg[3][31:0], coef_reg[4][31:0], sx, sy, sw);
      if (w == 0) begin
         r.zero_denominator = 1'b1;
         err_seen = 1'b1;
      end else begin
         r.out_x = fix_div(u, w);
         r.out_y = fix_div(v, w);
         acc = square_of(longint'(r.out_x) - longint'(tx))
             + square_of(longint'(r.out_y) - longint'(ty));
         if (homog) acc = acc + square_of(longint'(ONE_Q16) - longint'(tw));
         r.distance = (acc[127:64] != 0) ? 32'hffff_ffff : int_sqrt(acc[63:0]);
         // saturating set sum
         if ({1'b0, sum_acc} + 49'(r.distance) > 49'hffff_ffff_ffff)
            sum_acc = 48'hffff_ffff_ffff;
         else
            sum_acc = sum_acc + 48'(r.distance);
         // strictly larger wins, so the first of equal maxima stays
         if (r.distance > max_dist) begin
            max_dist = r.distance;
            max_pos  = pos_count;
         end
      end
      r.set_done  = last;
      r.error_sum = sum_acc;
      r.max_error = max_dist;
      r.max_index = max_pos;
      r.set_error = err_seen;
      pos_count = 10'((32'(pos_count) + 1) % MAX_POINTS);
      if (last) begin
         sum_acc = 0; max_dist = 0; max_pos = 0; pos_count = 0; err_seen = 0;
      end
      return r;
   endfunction

   task automatic cmp(input string name, input logic [63:0] exp_v, act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      score_type e;
      if (reset) begin
         coef_reg[0] <= RST_H00_H01;
         coef_reg[1] <= RST_H02_H10;
         coef_reg[2] <= RST_H11_H12;
         coef_reg[3] <= RST_H20_H21;
         coef_reg[4] <= 64'(RST_H22);
         homog <= 1'b0;
         sum_acc = 0; max_dist = 0; max_pos = 0; pos_count = 0; err_seen = 0;
         score_q.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (reg_idx_type'(csr_ch.index))
               REG_H00_H01: coef_reg[0] <= csr_ch.data;
               REG_H02_H10: coef_reg[1] <= csr_ch.data;
               REG_H11_H12: coef_reg[2] <= csr_ch.data;
               REG_H20_H21: coef_reg[3] <= csr_ch.data;
               REG_H22:     coef_reg[4] <= {32'h0, csr_ch.data[31:0]};
               REG_MODE:    homog <= csr_ch.data[0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            score_q.push_back(score_point(req_ch.src_x, req_ch.src_y, req_ch.src_w,
                                          req_ch.dst_x, req_ch.dst_y, req_ch.dst_w,
                                          req_ch.last_point));
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (score_q.size() == 0) begin
               $display("%0t: result word with no expectation, expected none, actual %h",
                        $time, rsp_ch.distance);
               fail_count++;
            end else begin
               e = score_q.pop_front();
               if (e.zero_denominator) zden_seen++;
               cmp("out_x", 64'(e.out_x), 64'(rsp_ch.out_x));
               cmp("out_y", 64'(e.out_y), 64'(rsp_ch.out_y));
               cmp("distance", 64'(e.distance), 64'(rsp_ch.distance));
               cmp("zero_denominator", 64'(e.zero_denominator), 64'(rsp_ch.zero_denominator));
               cmp("set_done", 64'(e.set_done), 64'(rsp_ch.set_done));
               cmp("error_sum", 64'(e.error_sum), 64'(rsp_ch.error_sum));
               cmp("max_error", 64'(e.max_error), 64'(rsp_ch.max_error));
               cmp("max_index", 64'(e.max_index), 64'(rsp_ch.max_index));
               cmp("set_error", 64'(e.set_error), 64'(rsp_ch.set_error));
            end
         end
      end
      pending <= score_q.size();
   end

   initial begin
      fail_count   = 0;
      pending      = 0;
      results_seen = 0;
      zden_seen    = 0;
   end

endmodule

// File: tb/sv/homography_reprojection_scorer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// homography_reprojection_scorer_tb
// stimulus and verdict for the homography reprojection scorer
// ----------------------------------------------------------------------------
// directed correspondences cover identity, projective and homogeneous setups
// with extreme coordinates, zero denominators and ties; random phases then
// reload every coefficient register while idle and stream point sets, one of
// them longer than the point counter. the checker predicts each result word.
// ----------------------------------------------------------------------------
module homography_reprojection_scorer_tb;
   import hrs_pkg::*;

   localparam int  CYCLE_LIMIT = 2_000_000;
   localparam int  SETTLE      = 120;   // settle margin after the last expected result word

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending, results_seen, zden_seen;
   int   cycle_count = 0;
   int   gap_pct  = 0;   // sender idle chance per word
   int   stall_pct = 0;  // receiver stall chance per cycle
   int   stall_left = 0;
   int   phases = 0;

   hrs_req_if req_ch ();
   hrs_rsp_if rsp_ch ();
   hrs_csr_if csr_ch ();

   homography_reprojection_scorer u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   homography_reprojection_scorer_checker u_chk (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .csr_ch       (csr_ch),
      .fail_count   (fail_count),
      .pending      (pending),
      .results_seen (results_seen),
      .zden_seen    (zden_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("homography_reprojection_scorer regression: fail");
         $finish;
      end
   end

   // receiver: ready drops in random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(99) < stall_pct) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= $urandom_range(1, 10) - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // one word on the request channel; valid stays up unless a gap follows
   task automatic send_point(input logic [31:0] sx, sy, sw, tx, ty, tw,
                             input logic last);
      req_ch.valid      <= 1'b1;
      req_ch.src_x      <= sx;
      req_ch.src_y      <= sy;
      req_ch.src_w      <= sw;
      req_ch.dst_x      <= tx;
      req_ch.dst_y      <= ty;
      req_ch.dst_w      <= tw;
      req_ch.last_point <= last;
      do @(posedge clock); while (!req_ch.ready);
      if ($urandom_range(99) < gap_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   task automatic write_reg(input reg_idx_type idx, input logic [63:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // hold the sender until every expected word has come back
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic load_matrix(input logic [31:0] h00, h01, h02, h10, h11, h12,
                              input logic [31:0] h20, h21, h22, input logic homog);
      write_reg(REG_H00_H01, {h00, h01});
      write_reg(REG_H02_H10, {h02, h10});
      write_reg(REG_H11_H12, {h11, h12});
      write_reg(REG_H20_H21, {h20, h21});
      write_reg(REG_H22, {$urandom(), h22});   // upper half is ignored
      write_reg(REG_MODE, {$urandom(), 31'h0, homog});
      phases++;
   endtask

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 7))
         0: return $urandom();
         1: case ($urandom_range(0, 4))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'hffff_ffff;
               3: return 32'h0;
               default: return ONE_Q16;
            endcase
         default: return 32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
      endcase
   endfunction

   function automatic logic [31:0] pick_coef(input logic [31:0] nominal);
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
         2: return 32'h0;
         default: return nominal + 32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
      endcase
   endfunction

   task automatic random_matrix();
      logic homog;
      logic [31:0] c [0:8];
      homog = 1'($urandom_range(0, 1));
      c[0] = pick_coef(32'h0100_0000); c[1] = pick_coef(0); c[2] = pick_coef(0);
      c[3] = pick_coef(0); c[4] = pick_coef(32'h0100_0000); c[5] = pick_coef(0);
      // a flat bottom row lets src_w = 0 hit the zero denominator in homogeneous mode
      if ($urandom_range(0, 2) == 0) begin
         c[6] = 0; c[7] = 0;
      end else begin
         c[6] = pick_coef(0) >>> 6; c[7] = pick_coef(0) >>> 6;
      end
      c[8] = pick_coef(32'h0100_0000);
      load_matrix(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8], homog);
   endtask

   task automatic random_points(input int count, input int last_pct);
      logic [31:0] sw;
      for (int i = 0; i < count; i++) begin
         sw = ($urandom_range(0, 5) == 0) ? 32'h0 : pick_coord();
         send_point(pick_coord(), pick_coord(), sw, pick_coord(), pick_coord(),
                    pick_coord(), (i == count - 1) || ($urandom_range(99) < last_pct));
      end
   endtask

   initial begin
      req_ch.valid <= 1'b0;
      req_ch.src_x <= '0; req_ch.src_y <= '0; req_ch.src_w <= '0;
      req_ch.dst_x <= '0; req_ch.dst_y <= '0; req_ch.dst_w <= '0;
      req_ch.last_point <= 1'b0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= REG_H00_H01;
      csr_ch.data  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset identity: origin, extremes, saturated distance, a tie
      send_point(0, 0, 0, 0, 0, 0, 1'b0);
      send_point(32'h7fff_ffff, 32'h8000_0000, 0, 32'h8000_0000, 32'h7fff_ffff, 0, 1'b0);
      send_point(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 0, 0, 32'h8000_0000, 1'b0);
      send_point(ONE_Q16, 0, 0, 0, 0, 0, 1'b0);
      send_point(0, ONE_Q16, 0, 0, 0, 0, 1'b0);
      send_point(32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff, ONE_Q16, 0, 0, 1'b1);
      drain();

      // w = x: zero denominator on the y axis, poisoning the set error
      load_matrix(32'h0100_0000, 0, 0, 0, 32'h0100_0000, 0, 32'h0100_0000, 0, 0, 1'b0);
      send_point(ONE_Q16, 32'h0003_0000, 0, 0, 0, 0, 1'b0);
      send_point(0, 32'h0005_0000, 0, 0, 0, 0, 1'b0);
      send_point(32'hffff_0000, 32'h7fff_ffff, 0, 32'h7fff_ffff, 0, 0, 1'b0);
      send_point(32'h0000_0001, 32'h8000_0000, 0, 0, 0, 0, 1'b1);
      drain();

      // homogeneous identity: supplied w, zero w, extreme target w
      load_matrix(32'h0100_0000, 0, 0, 0, 32'h0100_0000, 0, 0, 0, 32'h0100_0000, 1'b1);
      send_point(32'h0002_0000, 32'h0004_0000, 32'h0002_0000, ONE_Q16, 32'h0002_0000,
                 ONE_Q16, 1'b0);
      send_point(32'h0002_0000, 32'h0004_0000, 0, 0, 0, 32'h8000_0000, 1'b0);
      send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 0, 0, 32'h7fff_ffff, 1'b0);
      send_point(32'h0001_0000, 32'hffff_0000, 32'h8000_0000, 0, 0, 32'hffff_ffff, 1'b1);
      drain();

      // extreme coefficients everywhere
      load_matrix(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h7fff_ffff,
                  32'h8000_0000, 32'h0, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b1);
      random_points(6, 0);
      drain();
      load_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
      send_point(ONE_Q16, ONE_Q16, 0, 0, 0, 0, 1'b1);
      drain();

      // random phases, most with idling on both sides
      for (int p = 0; p < 8; p++) begin
         gap_pct   = (p % 3 == 2) ? 0 : 20;
         stall_pct = (p % 3 == 2) ? 0 : 10;
         random_matrix();
         random_points(95, 12);
         drain();
      end

      // a set longer than the point counter, small coordinates, identity-like map
      gap_pct = 5; stall_pct = 3;
      load_matrix(32'h0100_0000, 0, 0, 0, 32'h0100_0000, 0, 0, 0, 32'h0100_0000, 1'b0);
      for (int i = 0; i < 1030; i++)
         send_point($urandom_range(0, 32'h000f_ffff), $urandom_range(0, 32'h000f_ffff), 0,
                    $urandom_range(0, 32'h000f_ffff), $urandom_range(0, 32'h000f_ffff),
                    0, i == 1029);
      drain();

      // closing stretch without idling
      gap_pct = 0; stall_pct = 0;
      random_matrix();
      random_points(130, 10);
      drain();

      $display("covered %0d result words over %0d register setups, %0d zero denominators",
               results_seen, phases, zden_seen);
      if (fail_count == 0)
         $display("homography_reprojection_scorer regression: pass");
      else
         $display("homography_reprojection_scorer regression: fail");
      $finish;
   end

endmodule
